// File: rtl/lcgx_pkg.sv
// ----------------------------------------------------------------------------
// lcgx_pkg
// Shared widths, reset values, register indexes and types of the LCG
// keystream XOR cipher.
// ----------------------------------------------------------------------------
package lcgx_pkg;

  localparam int unsigned WordW  = 32;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned PosW   = 2;
  localparam int unsigned CntW   = 5;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [PosW-1:0] PosLast = 2'd3;

  // multiplier digits are 2 bits wide; divider retires 1 bit per cycle
  localparam logic [CntW-1:0] MulLastCnt = CntW'(WordW / 2 - 1);
  localparam logic [CntW-1:0] DivLastCnt = CntW'(WordW - 1);

  localparam logic [WordW-1:0] RstMult = 32'd213013;
  localparam logic [WordW-1:0] RstIncr = 32'd2531011;
  localparam logic [WordW-1:0] RstMod  = 32'h8000_0000;
  localparam logic [WordW-1:0] RstSeed = 32'd0;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_MULT = 2'd0,
    CFG_INCR = 2'd1,
    CFG_MOD  = 2'd2,
    CFG_SEED = 2'd3
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ADV_IDLE = 3'b001,
    ADV_MUL  = 3'b010,
    ADV_DIV  = 3'b100
  } adv_state_e;

  typedef struct packed {
    logic start;
  } adv_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } adv_stat_t;

endpackage

// File: rtl/lcgx_in_if.sv
// ----------------------------------------------------------------------------
// lcgx_in_if
// Input byte channel: valid/ready with data byte and chunk end flag.
// ----------------------------------------------------------------------------
interface lcgx_in_if;
  logic                       valid;
  logic                       ready;
  logic [lcgx_pkg::ByteW-1:0] data_byte;
  logic                       chunk_end;

  modport source (output valid, output data_byte, output chunk_end, input ready);
  modport sink   (input valid, input data_byte, input chunk_end, output ready);
endinterface

// File: rtl/lcgx_out_if.sv
// ----------------------------------------------------------------------------
// lcgx_out_if
// Output byte channel: valid/ready with result byte and chunk end flag.
// ----------------------------------------------------------------------------
interface lcgx_out_if;
  logic                       valid;
  logic                       ready;
  logic [lcgx_pkg::ByteW-1:0] out_byte;
  logic                       chunk_end_out;

  modport source (output valid, output out_byte, output chunk_end_out, input ready);
  modport sink   (input valid, input out_byte, input chunk_end_out, output ready);
endinterface

// File: rtl/lcgx_adv.sv
// ----------------------------------------------------------------------------
// lcgx_adv
// Serial state advance: (mult * state + incr) mod 2^32, then mod m.
// Radix-4 shift-add multiply, then restoring remainder.
// ----------------------------------------------------------------------------
module lcgx_adv (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  lcgx_pkg::adv_ctrl_t              ctrl_i,
  input  logic [lcgx_pkg::WordW-1:0]       state_i,
  input  logic [lcgx_pkg::WordW-1:0]       mult_i,
  input  logic [lcgx_pkg::WordW-1:0]       incr_i,
  input  logic [lcgx_pkg::WordW-1:0]       mod_i,
  output lcgx_pkg::adv_stat_t              stat_o,
  output logic [lcgx_pkg::WordW-1:0]       next_o
);

  lcgx_pkg::adv_state_e st_q, st_d;
  logic [lcgx_pkg::CntW-1:0]  cnt_q, cnt_d;
  logic                       done_q, done_d;
  logic [lcgx_pkg::WordW-1:0] acc_q, acc_d;
  logic [lcgx_pkg::WordW-1:0] mc_q, mc_d;
  logic [lcgx_pkg::WordW-1:0] mc3_q, mc3_d;
  logic [lcgx_pkg::WordW-1:0] sh_q, sh_d;
  logic [lcgx_pkg::WordW-1:0] rem_q, rem_d;
  logic [lcgx_pkg::WordW-1:0] m_q, m_d;

  logic [lcgx_pkg::WordW-1:0] addend;
  logic [lcgx_pkg::WordW:0]   trial;
  logic [lcgx_pkg::WordW:0]   diff;

  always_comb begin
    case (sh_q[1:0])
      2'd0:    addend = '0;
      2'd1:    addend = mc_q;
      2'd2:    addend = {mc_q[lcgx_pkg::WordW-2:0], 1'b0};
      default: addend = mc3_q;
    endcase
    trial = {rem_q, acc_q[lcgx_pkg::WordW-1]};
    diff  = trial - {1'b0, m_q};
  end

  always_comb begin
    st_d   = st_q;
    cnt_d  = cnt_q;
    done_d = done_q;
    acc_d  = acc_q;
    mc_d   = mc_q;
    mc3_d  = mc3_q;
    sh_d   = sh_q;
    rem_d  = rem_q;
    m_d    = m_q;
    if (ctrl_i.start) begin
      st_d   = lcgx_pkg::ADV_MUL;
      cnt_d  = '0;
      done_d = 1'b0;
      acc_d  = incr_i;
      mc_d   = mult_i;
      mc3_d  = mult_i + {mult_i[lcgx_pkg::WordW-2:0], 1'b0};
      sh_d   = state_i;
      rem_d  = '0;
      m_d    = (mod_i == '0) ? lcgx_pkg::WordW'(1) : mod_i;
    end else begin
      case (st_q)
        lcgx_pkg::ADV_MUL: begin
          acc_d = acc_q + addend;
          mc_d  = {mc_q[lcgx_pkg::WordW-3:0], 2'b00};
          mc3_d = {mc3_q[lcgx_pkg::WordW-3:0], 2'b00};
          sh_d  = {2'b00, sh_q[lcgx_pkg::WordW-1:2]};
          cnt_d = cnt_q + 1'b1;
          if (cnt_q == lcgx_pkg::MulLastCnt) begin
            st_d  = lcgx_pkg::ADV_DIV;
            cnt_d = '0;
          end
        end
        lcgx_pkg::ADV_DIV: begin
          rem_d = diff[lcgx_pkg::WordW] ? trial[lcgx_pkg::WordW-1:0]
                                        : diff[lcgx_pkg::WordW-1:0];
          acc_d = {acc_q[lcgx_pkg::WordW-2:0], 1'b0};
          cnt_d = cnt_q + 1'b1;
          if (cnt_q == lcgx_pkg::DivLastCnt) begin
            st_d   = lcgx_pkg::ADV_IDLE;
            cnt_d  = '0;
            done_d = 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= lcgx_pkg::ADV_IDLE;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      st_q   <= st_d;
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    mc_q  <= mc_d;
    mc3_q <= mc3_d;
    sh_q  <= sh_d;
    rem_q <= rem_d;
    m_q   <= m_d;
  end

  assign stat_o.busy = (st_q != lcgx_pkg::ADV_IDLE);
  assign stat_o.done = done_q;
  assign next_o      = rem_q;

endmodule

// File: rtl/lcg_keystream_xor_cipher_top.sv
// ----------------------------------------------------------------------------
// lcg_keystream_xor_cipher_top
// Byte stream cipher keyed by a 32-bit linear congruential generator.
//
// in_s carries one byte per beat; out_m returns it XORed with the current
// generator state byte (low byte first) plus the chunk end flag unchanged.
// Configuration: cfg_we_i writes cfg_wdata_i to register cfg_idx_i
// (0 multiplier, 1 increment, 2 modulus, 3 seed). A seed write reloads the
// state and restarts at the low byte. Write only while the block is idle.
// A result is registered and appears in the cycle after its input beat.
// The first three bytes of a word are taken without waiting for the next
// state, which is computed in the background by a serial unit (radix-4
// multiply, then bit-serial remainder), started whenever the state or a
// register changes; the fourth byte waits for it.
// Reset: registers take their defaults, the state is 0 and the advance
// unit starts at once. A stalled receiver holds the output register, and
// no new beat is taken until it drains.
// ----------------------------------------------------------------------------
module lcg_keystream_xor_cipher_top (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  lcgx_in_if.sink                            in_s,
  lcgx_out_if.source                         out_m,
  input  logic                               cfg_we_i,
  input  logic [lcgx_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  logic [lcgx_pkg::WordW-1:0]         cfg_wdata_i
);

  logic [lcgx_pkg::WordW-1:0] mult_q, mult_d;
  logic [lcgx_pkg::WordW-1:0] incr_q, incr_d;
  logic [lcgx_pkg::WordW-1:0] mod_q, mod_d;
  logic [lcgx_pkg::WordW-1:0] state_q, state_d;
  logic [lcgx_pkg::PosW-1:0]  pos_q, pos_d;
  logic                       kick_q, kick_d;
  logic                       oval_q, oval_d;
  logic [lcgx_pkg::ByteW-1:0] obyte_q, obyte_d;
  logic                       oend_q, oend_d;

  lcgx_pkg::adv_ctrl_t        adv_ctrl;
  lcgx_pkg::adv_stat_t        adv_stat;
  logic [lcgx_pkg::WordW-1:0] adv_next;

  logic                       in_acc;
  logic                       adv_ok;
  logic                       commit;
  logic [lcgx_pkg::ByteW-1:0] key;

  lcgx_adv u_adv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (adv_ctrl),
    .state_i (state_q),
    .mult_i  (mult_q),
    .incr_i  (incr_q),
    .mod_i   (mod_q),
    .stat_o  (adv_stat),
    .next_o  (adv_next)
  );

  assign adv_ctrl.start = kick_q;
  assign adv_ok   = adv_stat.done & ~kick_q;
  assign in_s.ready = (~oval_q | out_m.ready) & ((pos_q != lcgx_pkg::PosLast) | adv_ok);
  assign in_acc   = in_s.valid & in_s.ready;
  assign commit   = in_acc & (pos_q == lcgx_pkg::PosLast);

  always_comb begin
    case (pos_q)
      2'd0:    key = state_q[7:0];
      2'd1:    key = state_q[15:8];
      2'd2:    key = state_q[23:16];
      default: key = state_q[31:24];
    endcase
  end

  always_comb begin
    mult_d  = mult_q;
    incr_d  = incr_q;
    mod_d   = mod_q;
    state_d = state_q;
    pos_d   = pos_q;
    kick_d  = cfg_we_i | commit;
    oval_d  = oval_q & ~out_m.ready;
    obyte_d = obyte_q;
    oend_d  = oend_q;
    if (in_acc) begin
      oval_d  = 1'b1;
      obyte_d = in_s.data_byte ^ key;
      oend_d  = in_s.chunk_end;
      pos_d   = pos_q + 1'b1;
      if (commit) begin
        state_d = adv_next;
      end
    end
    if (cfg_we_i) begin
      case (lcgx_pkg::cfg_idx_e'(cfg_idx_i))
        lcgx_pkg::CFG_MULT: mult_d = cfg_wdata_i;
        lcgx_pkg::CFG_INCR: incr_d = cfg_wdata_i;
        lcgx_pkg::CFG_MOD:  mod_d  = cfg_wdata_i;
        lcgx_pkg::CFG_SEED: begin
          state_d = cfg_wdata_i;
          pos_d   = '0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mult_q  <= lcgx_pkg::RstMult;
      incr_q  <= lcgx_pkg::RstIncr;
      mod_q   <= lcgx_pkg::RstMod;
      state_q <= lcgx_pkg::RstSeed;
      pos_q   <= '0;
      kick_q  <= 1'b1;
      oval_q  <= 1'b0;
    end else begin
      mult_q  <= mult_d;
      incr_q  <= incr_d;
      mod_q   <= mod_d;
      state_q <= state_d;
      pos_q   <= pos_d;
      kick_q  <= kick_d;
      oval_q  <= oval_d;
    end
  end

  always_ff @(posedge clk_i) begin
    obyte_q <= obyte_d;
    oend_q  <= oend_d;
  end

  assign out_m.valid         = oval_q;
  assign out_m.out_byte      = obyte_q;
  assign out_m.chunk_end_out = oend_q;

  // state advance only from a finished, current computation
  a_commit_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit |-> (adv_stat.done && !adv_stat.busy && !kick_q))
    else $error("state advanced before the next state was ready");

  a_acc_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> oval_q)
    else $error("accepted beat produced no result");

  a_kick_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    kick_q |=> !adv_stat.done)
    else $error("advance unit did not restart");

  a_seed_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_we_i && cfg_idx_i == lcgx_pkg::CFG_SEED) |=> (pos_q == '0))
    else $error("seed write did not clear byte position");

endmodule
